@@ src/aapr_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the axis-angle point rotation block
package aapr_pkg;

    // geometry and register file
    localparam int DIM          = 3;
    localparam int NUM_REGS     = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // fixed-point formats
    localparam int FRAC_SHIFT   = 42;
    localparam int KS_SHIFT     = 14;
    localparam int R_WIDTH      = 49;
    localparam int R_LO_W       = 25;
    localparam int R_HI_W       = R_WIDTH - R_LO_W;
    localparam int KK_WIDTH     = 33;
    localparam int SQ_WIDTH     = 32;
    localparam int OMC_WIDTH    = 17;

    // matrix build and point queue
    localparam int BUILD_LAT    = 4;
    localparam int BUILD_CNT_W  = 3;
    localparam int QUEUE_DEPTH  = 4;

    localparam int COORD_WIDTH_DEF = 32;

    localparam logic signed [CFG_DATA_W-1:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [R_WIDTH-1:0]    R_ONE   = R_WIDTH'(64'sd1 <<< FRAC_SHIFT);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_X    = 3'd0,
        REG_AXIS_Y    = 3'd1,
        REG_AXIS_Z    = 3'd2,
        REG_SIN_THETA = 3'd3,
        REG_COS_THETA = 3'd4
    } t_reg_idx;

    // rotation matrix, entry i*DIM+j holds row i column j, Q.42
    typedef logic [DIM*DIM-1:0][R_WIDTH-1:0] t_rmat;

endpackage

@@ src/aapr_cfg_if.sv @@
`timescale 1ns / 1ps
// configuration write channel
interface aapr_cfg_if
    import aapr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/aapr_point_if.sv @@
`timescale 1ns / 1ps
// input point channel
interface aapr_point_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

@@ src/aapr_result_if.sv @@
`timescale 1ns / 1ps
// rotated point result channel
interface aapr_result_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic signed [COORD_WIDTH-1:0] rotated_z;
    logic                          saturated;

    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    output saturated, input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                    input saturated, output ready);
endinterface

@@ src/aapr_matrix.sv @@
`timescale 1ns / 1ps
// configuration registers and rotation matrix build pipeline
module aapr_matrix
    import aapr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    aapr_cfg_if.sink   i_cfg,
    output t_rmat      o_rmat,
    output logic       o_ready
);

    logic signed [CFG_DATA_W-1:0] r_ax, r_ay, r_az, r_sin, r_cos;
    logic [BUILD_CNT_W-1:0]       r_cnt;
    logic                         w_wr;

    // stage 1: products of the configuration values
    logic signed [SQ_WIDTH-1:0]   r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    logic signed [SQ_WIDTH-1:0]   r_xs, r_ys, r_zs;
    logic signed [OMC_WIDTH-1:0]  r_omc;
    // stage 2: entries of K*K
    logic signed [KK_WIDTH-1:0]   r_kd0, r_kd1, r_kd2, r_kxy, r_kxz, r_kyz;
    // stage 3: K*K scaled by one minus cosine
    logic signed [R_WIDTH-1:0]    r_md0, r_md1, r_md2, r_mxy, r_mxz, r_myz;
    // stage 4: matrix
    t_rmat                        r_rmat;

    function automatic logic signed [R_WIDTH-1:0] ks_term(input logic signed [SQ_WIDTH-1:0] v);
        ks_term = R_WIDTH'(v) <<< KS_SHIFT;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    // register writes and rebuild countdown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax  <= '0;
            r_ay  <= '0;
            r_az  <= ONE_Q14;
            r_sin <= '0;
            r_cos <= ONE_Q14;
            r_cnt <= BUILD_CNT_W'(BUILD_LAT);
        end else begin
            if (w_wr) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_AXIS_X:    r_ax  <= $signed(i_cfg.data);
                    REG_AXIS_Y:    r_ay  <= $signed(i_cfg.data);
                    REG_AXIS_Z:    r_az  <= $signed(i_cfg.data);
                    REG_SIN_THETA: r_sin <= $signed(i_cfg.data);
                    REG_COS_THETA: r_cos <= $signed(i_cfg.data);
                    default: ;
                endcase
            end
            if (w_wr) begin
                r_cnt <= BUILD_CNT_W'(BUILD_LAT);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - BUILD_CNT_W'(1);
            end
        end
    end

    // free-running build pipeline: products, K*K, scaling by one minus cosine, then the matrix
    always_ff @(posedge i_clk) begin
        r_xx  <= SQ_WIDTH'(r_ax) * SQ_WIDTH'(r_ax);
        r_yy  <= SQ_WIDTH'(r_ay) * SQ_WIDTH'(r_ay);
        r_zz  <= SQ_WIDTH'(r_az) * SQ_WIDTH'(r_az);
        r_xy  <= SQ_WIDTH'(r_ax) * SQ_WIDTH'(r_ay);
        r_xz  <= SQ_WIDTH'(r_ax) * SQ_WIDTH'(r_az);
        r_yz  <= SQ_WIDTH'(r_ay) * SQ_WIDTH'(r_az);
        r_xs  <= SQ_WIDTH'(r_ax) * SQ_WIDTH'(r_sin);
        r_ys  <= SQ_WIDTH'(r_ay) * SQ_WIDTH'(r_sin);
        r_zs  <= SQ_WIDTH'(r_az) * SQ_WIDTH'(r_sin);
        r_omc <= OMC_WIDTH'(ONE_Q14) - OMC_WIDTH'(r_cos);

        // K*K = a*a' - |a|^2 * I
        r_kd0 <= -(KK_WIDTH'(r_yy) + KK_WIDTH'(r_zz));
        r_kd1 <= -(KK_WIDTH'(r_xx) + KK_WIDTH'(r_zz));
        r_kd2 <= -(KK_WIDTH'(r_xx) + KK_WIDTH'(r_yy));
        r_kxy <= KK_WIDTH'(r_xy);
        r_kxz <= KK_WIDTH'(r_xz);
        r_kyz <= KK_WIDTH'(r_yz);

        r_md0 <= R_WIDTH'(r_kd0) * R_WIDTH'(r_omc);
        r_md1 <= R_WIDTH'(r_kd1) * R_WIDTH'(r_omc);
        r_md2 <= R_WIDTH'(r_kd2) * R_WIDTH'(r_omc);
        r_mxy <= R_WIDTH'(r_kxy) * R_WIDTH'(r_omc);
        r_mxz <= R_WIDTH'(r_kxz) * R_WIDTH'(r_omc);
        r_myz <= R_WIDTH'(r_kyz) * R_WIDTH'(r_omc);

        // R = I + K*sin + K*K*(1-cos)
        r_rmat[0] <= R_ONE + r_md0;
        r_rmat[1] <= r_mxy - ks_term(r_zs);
        r_rmat[2] <= r_mxz + ks_term(r_ys);
        r_rmat[3] <= r_mxy + ks_term(r_zs);
        r_rmat[4] <= R_ONE + r_md1;
        r_rmat[5] <= r_myz - ks_term(r_xs);
        r_rmat[6] <= r_mxz - ks_term(r_ys);
        r_rmat[7] <= r_myz + ks_term(r_xs);
        r_rmat[8] <= R_ONE + r_md2;
    end

    assign o_rmat  = r_rmat;
    assign o_ready = (r_cnt == '0);

`ifndef NO_ASSERTIONS
    // a register write always holds off new points while the matrix rebuilds
    a_write_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> !o_ready)
        else $error("matrix reported ready right after a register write");
`endif

endmodule

@@ src/aapr_front.sv @@
`timescale 1ns / 1ps
// point intake and queue toward the rotation datapath
module aapr_front
    import aapr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    aapr_point_if.sink                        i_point,
    input  logic                              i_mat_ready,
    output logic                              o_head_valid,
    output logic [DIM-1:0][COORD_WIDTH-1:0]   o_head,
    input  logic                              i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [DIM-1:0][COORD_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]                r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]                r_count;
    logic                            w_push;

    // take items only with a settled matrix and room in the queue
    assign i_point.ready = i_mat_ready && (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push        = i_point.valid && i_point.ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= {i_point.point_z, i_point.point_y, i_point.point_x};
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!w_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

`ifndef NO_ASSERTIONS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("point queue filled beyond its depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("point queue popped while empty");
`endif

endmodule

@@ src/aapr_back.sv @@
`timescale 1ns / 1ps
// matrix-vector multiply, rounding, saturation and output register
module aapr_back
    import aapr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_rmat                             i_rmat,
    input  logic                              i_head_valid,
    input  logic [DIM-1:0][COORD_WIDTH-1:0]   i_head,
    output logic                              o_pop,
    aapr_result_if.source                     o_result
);

    localparam int CW     = COORD_WIDTH;
    localparam int PL     = CW / 2;
    localparam int PH     = CW - PL;
    localparam int LL_W   = R_LO_W + PL;
    localparam int LH_W   = R_LO_W + 1 + PH;
    localparam int HL_W   = R_HI_W + PL + 1;
    localparam int HH_W   = R_HI_W + PH;
    localparam int PROD_W = R_WIDTH + CW;
    localparam int ACC_W  = PROD_W + 2;
    localparam int TOP_LO = FRAC_SHIFT + CW - 1;
    localparam int NENT   = DIM * DIM;

    localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic [CW-1:0]           C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]           C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                      w_adv;
    logic                      r_v1, r_v2, r_v3;
    logic [LL_W-1:0]           r_ll   [NENT];
    logic signed [LH_W-1:0]    r_lh   [NENT];
    logic signed [HL_W-1:0]    r_hl   [NENT];
    logic signed [HH_W-1:0]    r_hh   [NENT];
    logic signed [PROD_W-1:0]  r_prod [NENT];
    logic signed [ACC_W-1:0]   r_acc  [DIM];
    logic [CW-1:0]             w_val  [DIM];
    logic [DIM-1:0]            w_clip;
    logic                      r_out_valid;
    logic [CW-1:0]             r_out  [DIM];
    logic                      r_out_sat;

    // whole datapath moves when the output register is free or being taken
    assign w_adv = !r_out_valid || o_result.ready;
    assign o_pop = w_adv && i_head_valid;

    // valid bits along the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    for (genvar gi = 0; gi < DIM; gi++) begin : g_row
        for (genvar gj = 0; gj < DIM; gj++) begin : g_col
            localparam int E = gi * DIM + gj;
            logic [R_LO_W-1:0]        w_rlo;
            logic signed [R_HI_W-1:0] w_rhi;
            logic [PL-1:0]            w_plo;
            logic signed [PH-1:0]     w_phi;

            // split operands so each partial product stays narrow
            assign w_rlo = i_rmat[E][R_LO_W-1:0];
            assign w_rhi = $signed(i_rmat[E][R_WIDTH-1:R_LO_W]);
            assign w_plo = i_head[gj][PL-1:0];
            assign w_phi = $signed(i_head[gj][CW-1:PL]);

            // partial products, then recombined full product
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_ll[E]   <= LL_W'(w_rlo) * LL_W'(w_plo);
                    r_lh[E]   <= LH_W'($signed({1'b0, w_rlo})) * LH_W'(w_phi);
                    r_hl[E]   <= HL_W'(w_rhi) * HL_W'($signed({1'b0, w_plo}));
                    r_hh[E]   <= HH_W'(w_rhi) * HH_W'(w_phi);
                    r_prod[E] <= $signed(PROD_W'(r_ll[E]))
                               + (PROD_W'(r_lh[E]) <<< PL)
                               + (PROD_W'(r_hl[E]) <<< R_LO_W)
                               + (PROD_W'(r_hh[E]) <<< (R_LO_W + PL));
                end
            end
        end

        // row sum with round-half-up constant
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_acc[gi] <= ACC_W'(r_prod[gi*DIM]) + ACC_W'(r_prod[gi*DIM+1])
                           + ACC_W'(r_prod[gi*DIM+2]) + RND;
            end
        end

        // shift to Q16.16 and clip to the coordinate width
        logic [ACC_W-TOP_LO-1:0] w_top;
        logic                    w_fits;
        assign w_top       = r_acc[gi][ACC_W-1:TOP_LO];
        assign w_fits      = (&w_top) || !(|w_top);
        assign w_clip[gi]  = !w_fits;
        assign w_val[gi]   = w_fits ? r_acc[gi][TOP_LO:FRAC_SHIFT]
                           : (r_acc[gi][ACC_W-1] ? C_MIN : C_MAX);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out[0]  <= w_val[0];
            r_out[1]  <= w_val[1];
            r_out[2]  <= w_val[2];
            r_out_sat <= |w_clip;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.rotated_x = $signed(r_out[0]);
    assign o_result.rotated_y = $signed(r_out[1]);
    assign o_result.rotated_z = $signed(r_out[2]);
    assign o_result.saturated = r_out_sat;

`ifndef NO_ASSERTIONS
    // a clipped result must show a rail value on some coordinate
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |->
            (r_out[0] == C_MAX || r_out[0] == C_MIN || r_out[1] == C_MAX ||
             r_out[1] == C_MIN || r_out[2] == C_MAX || r_out[2] == C_MIN))
        else $error("saturation flag set without a clipped coordinate");

    // a stalled output freezes every item still in flight
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> $stable({r_v1, r_v2, r_v3, r_out_valid}))
        else $error("datapath moved while the output was stalled");
`endif

endmodule

@@ src/axis_angle_point_rotation.sv @@
`timescale 1ns / 1ps
// top level of the axis-angle point rotation block
// Rotates each Q16.16 point about the axis (axis_x, axis_y, axis_z) by the angle whose
// sine and cosine are written as Q2.14 registers, using R = I + K*sin + K*K*(1-cos).
// One point is accepted per clock and one result leaves per clock while the output is
// not stalled and the matrix has settled; an accepted point passes through the queue,
// the partial products and the product recombination, then the row sum with its rounding
// constant, which the output register clips and holds. The rate is set by the 36
// partial-product multipliers, four per matrix entry, working in parallel on every point.
// The matrix is rebuilt by a four-stage pipeline from the registers: after reset and
// after every register write the point input holds ready low while it settles. Register
// writes are taken every cycle; writes beyond the register list are ignored.
module axis_angle_point_rotation
    import aapr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    aapr_cfg_if.sink         i_cfg,
    aapr_point_if.sink       i_point,
    aapr_result_if.source    o_result
);

    t_rmat                            w_rmat;
    logic                             w_mat_ready;
    logic                             w_head_valid;
    logic [DIM-1:0][COORD_WIDTH-1:0]  w_head;
    logic                             w_pop;

    // configuration and matrix build
    aapr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_rmat  (w_rmat),
        .o_ready (w_mat_ready)
    );

    // point intake and queue
    aapr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point      (i_point),
        .i_mat_ready  (w_mat_ready),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // rotation datapath
    aapr_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rmat       (w_rmat),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_result     (o_result)
    );

endmodule

@@ tb/axis_angle_point_rotation_checker.sv @@
`timescale 1ns / 1ps
// result checker for the axis-angle point rotation block: predicts every rotated point
module axis_angle_point_rotation_checker
    import aapr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_pt_valid,
    input  logic                          i_pt_ready,
    input  logic signed [COORD_WIDTH-1:0] i_pt_x,
    input  logic signed [COORD_WIDTH-1:0] i_pt_y,
    input  logic signed [COORD_WIDTH-1:0] i_pt_z,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic signed [COORD_WIDTH-1:0] i_res_x,
    input  logic signed [COORD_WIDTH-1:0] i_res_y,
    input  logic signed [COORD_WIDTH-1:0] i_res_z,
    input  logic                          i_res_sat,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_clipped
);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          sat;
    } t_rotated;

    // rounding offset and clip bounds on the wide accumulator
    localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (FRAC_SHIFT - 1);
    localparam logic signed [127:0] CLIP_HI  = (128'sd1 <<< (COORD_WIDTH - 1)) - 128'sd1;
    localparam logic signed [127:0] CLIP_LO  = -(128'sd1 <<< (COORD_WIDTH - 1));

    logic signed [CFG_DATA_W-1:0] axis_x, axis_y, axis_z, sin_th, cos_th;
    t_rotated                     rotated_q [$];
    int                           fail_cnt;
    int                           checked_cnt;
    int                           clipped_cnt;

    // rodrigues matrix built exactly, then one rounding and a clip per coordinate
    function automatic t_rotated rotate_point(input logic signed [COORD_WIDTH-1:0] px,
                                              input logic signed [COORD_WIDTH-1:0] py,
                                              input logic signed [COORD_WIDTH-1:0] pz);
        longint                        ax, ay, az, sn, one_m_cos, kk;
        longint                        skew [DIM][DIM];
        longint                        rmat [DIM][DIM];
        logic signed [127:0]           pw [DIM];
        logic signed [127:0]           entry, acc, scaled;
        logic signed [COORD_WIDTH-1:0] coord [DIM];
        logic                          clip;
        t_rotated                      r;
        ax = axis_x;
        ay = axis_y;
        az = axis_z;
        sn = sin_th;
        one_m_cos = longint'(ONE_Q14) - longint'(cos_th);

        // cross-product matrix of the axis
        skew[0][0] = 0;   skew[0][1] = -az; skew[0][2] = ay;
        skew[1][0] = az;  skew[1][1] = 0;   skew[1][2] = -ax;
        skew[2][0] = -ay; skew[2][1] = ax;  skew[2][2] = 0;

        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                kk = 0;
                for (int n = 0; n < DIM; n++)
                    kk += skew[i][n] * skew[n][j];
                rmat[i][j] = ((skew[i][j] * sn) <<< KS_SHIFT) + kk * one_m_cos +
                             ((i == j) ? (longint'(1) <<< FRAC_SHIFT) : longint'(0));
            end
        end

        pw[0] = px;
        pw[1] = py;
        pw[2] = pz;
        clip = 1'b0;
        for (int i = 0; i < DIM; i++) begin
            acc = '0;
            for (int j = 0; j < DIM; j++) begin
                entry = rmat[i][j];
                acc = acc + entry * pw[j];
            end
            scaled = (acc + HALF_LSB) >>> FRAC_SHIFT;
            if (scaled > CLIP_HI) begin
                coord[i] = CLIP_HI[COORD_WIDTH-1:0];
                clip = 1'b1;
            end else if (scaled < CLIP_LO) begin
                coord[i] = CLIP_LO[COORD_WIDTH-1:0];
                clip = 1'b1;
            end else begin
                coord[i] = scaled[COORD_WIDTH-1:0];
            end
        end
        r.x = coord[0];
        r.y = coord[1];
        r.z = coord[2];
        r.sat = clip;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        fail_cnt++;
    endtask

    // watch all three channels at each clock
    always @(posedge i_clk) begin : watch
        t_rotated want;
        if (!i_rst_n) begin
            axis_x = '0;
            axis_y = '0;
            axis_z = ONE_Q14;
            sin_th = '0;
            cos_th = ONE_Q14;
            rotated_q.delete();
            fail_cnt = 0;
            checked_cnt = 0;
            clipped_cnt = 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_AXIS_X:    axis_x = i_cfg_data;
                    REG_AXIS_Y:    axis_y = i_cfg_data;
                    REG_AXIS_Z:    axis_z = i_cfg_data;
                    REG_SIN_THETA: sin_th = i_cfg_data;
                    REG_COS_THETA: cos_th = i_cfg_data;
                    default: ;  // index past the register list is dropped
                endcase
            end

            // accepted point
            if (i_pt_valid && i_pt_ready)
                rotated_q.insert(rotated_q.size(), rotate_point(i_pt_x, i_pt_y, i_pt_z));

            // accepted result against the oldest prediction
            if (i_res_valid && i_res_ready) begin
                if (rotated_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d sat %0d",
                             $time, i_res_x, i_res_y, i_res_z, i_res_sat);
                    fail_cnt++;
                end else begin
                    want = rotated_q.pop_front();
                    checked_cnt++;
                    if (want.sat)
                        clipped_cnt++;
                    if (i_res_x !== want.x)
                        flag_mismatch("rotated_x", want.x, i_res_x);
                    if (i_res_y !== want.y)
                        flag_mismatch("rotated_y", want.y, i_res_y);
                    if (i_res_z !== want.z)
                        flag_mismatch("rotated_z", want.z, i_res_z);
                    if (i_res_sat !== want.sat)
                        flag_mismatch("saturated", want.sat, i_res_sat);
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= rotated_q.size();
        o_checked    <= checked_cnt;
        o_clipped    <= clipped_cnt;
    end

endmodule

@@ tb/axis_angle_point_rotation_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the axis-angle point rotation block: stimulus, flow control, verdict
module axis_angle_point_rotation_tb;
    import aapr_pkg::*;

    localparam int CW            = COORD_WIDTH_DEF;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_LEN      = 80;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_POINTS  = 72;
    localparam int HOLD_PHASE    = 4;
    localparam int DRAIN_PHASE   = 6;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_ONE = CW'(1) <<< 16;

    // q2.14 values used by the directed settings
    localparam logic signed [15:0] Q_ONE   = ONE_Q14;
    localparam logic signed [15:0] Q_NONE  = -16'sd16384;
    localparam logic signed [15:0] Q_RT2   = 16'sd11585;
    localparam logic signed [15:0] Q_AXMAX = 16'sd32767;
    localparam logic signed [15:0] Q_AXMIN = -16'sd32768;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_token = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   points_sent = 0;
    int   settings_used = 0;
    int   fail_count, pending, checked, clipped;

    aapr_cfg_if                       cfg_if ();
    aapr_point_if  #(.COORD_WIDTH(CW)) pt_if ();
    aapr_result_if #(.COORD_WIDTH(CW)) res_if ();

    axis_angle_point_rotation #(.COORD_WIDTH(CW)) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_if),
        .i_point  (pt_if),
        .o_result (res_if)
    );

    axis_angle_point_rotation_checker #(.COORD_WIDTH(CW)) rot_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_index  (cfg_if.index),
        .i_cfg_data   (cfg_if.data),
        .i_pt_valid   (pt_if.valid),
        .i_pt_ready   (pt_if.ready),
        .i_pt_x       (pt_if.point_x),
        .i_pt_y       (pt_if.point_y),
        .i_pt_z       (pt_if.point_z),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_x      (res_if.rotated_x),
        .i_res_y      (res_if.rotated_y),
        .i_res_z      (res_if.rotated_z),
        .i_res_sat    (res_if.saturated),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_clipped    (clipped)
    );

    // clock
    always #CLK_HALF clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycle_cnt,
                     pending);
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when requested
    always @(posedge clk) begin
        if (hold_token != hold_served) begin
            hold_served <= hold_token;
            hold_left   <= HOLD_LEN;
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // random coordinate, weighted toward extremes and moderate magnitudes
    function automatic logic signed [CW-1:0] rand_coord();
        logic signed [CW-1:0] v;
        v = CW'($urandom);
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: v = C_MAX;
                    1: v = C_MIN;
                    2: v = '0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            1, 2, 3: ;
            default: v = v >>> $urandom_range(8, 20);
        endcase
        return v;
    endfunction

    task automatic send_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                              input logic signed [CW-1:0] pz);
        // optional gap before the item
        if ($urandom_range(99) < send_idle_pct) begin
            pt_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        pt_if.valid   <= 1'b1;
        pt_if.point_x <= px;
        pt_if.point_y <= py;
        pt_if.point_z <= pz;
        do @(posedge clk); while (!pt_if.ready);
        points_sent++;
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain();
        pt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    task automatic set_rotation(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                input logic signed [15:0] az, input logic signed [15:0] sn,
                                input logic signed [15:0] cs, input bit stray);
        drain();
        // a write past the register list must leave the registers alone
        if (stray)
            write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        write_reg(REG_AXIS_X, ax);
        write_reg(REG_AXIS_Y, ay);
        write_reg(REG_AXIS_Z, az);
        write_reg(REG_SIN_THETA, sn);
        write_reg(REG_COS_THETA, cs);
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    // axis and angle for one random phase
    task automatic pick_rotation(input int phase);
        logic signed [15:0] ax, ay, az, sn, cs;
        if (phase == 0) begin
            ax = Q_AXMAX; ay = Q_AXMIN; az = Q_AXMAX; sn = Q_NONE; cs = Q_NONE;
        end else if (phase == 1) begin
            ax = Q_AXMIN; ay = Q_AXMAX; az = Q_AXMIN; sn = Q_ONE; cs = Q_ONE;
        end else if ($urandom_range(1) == 0) begin
            // unit axis and a real angle
            case ($urandom_range(5))
                0: begin ax = Q_ONE; ay = 0;     az = 0;      end
                1: begin ax = 0;     ay = Q_ONE; az = 0;      end
                2: begin ax = 0;     ay = 0;     az = Q_ONE;  end
                3: begin ax = 9459;  ay = 9459;  az = 9459;   end
                4: begin ax = 0;     ay = Q_RT2; az = -Q_RT2; end
                default: begin ax = -9459; ay = 9459; az = -9459; end
            endcase
            case ($urandom_range(7))
                0: begin sn = 0;      cs = Q_ONE;  end
                1: begin sn = Q_ONE;  cs = 0;      end
                2: begin sn = 0;      cs = Q_NONE; end
                3: begin sn = Q_NONE; cs = 0;      end
                4: begin sn = Q_RT2;  cs = Q_RT2;  end
                5: begin sn = 8192;   cs = 14189;  end
                6: begin sn = 14189;  cs = -8192;  end
                default: begin sn = -Q_RT2; cs = Q_RT2; end
            endcase
        end else begin
            // arbitrary axis, sine and cosine unrelated
            ax = 16'($urandom);
            ay = 16'($urandom);
            az = 16'($urandom);
            sn = 16'($urandom_range(2 * ONE_Q14)) - ONE_Q14;
            cs = 16'($urandom_range(2 * ONE_Q14)) - ONE_Q14;
        end
        set_rotation(ax, ay, az, sn, cs, $urandom_range(3) == 0);
    endtask

    initial begin
        rst_n          <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= REG_AXIS_X;
        cfg_if.data    <= '0;
        pt_if.valid    <= 1'b0;
        pt_if.point_x  <= '0;
        pt_if.point_y  <= '0;
        pt_if.point_z  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // identity after reset, coordinate extremes
        send_point(0, 0, 0);
        send_point(C_MAX, C_MIN, 1);
        send_point(C_MIN, C_MAX, -1);
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_ONE, -C_ONE, 32'sh0001_8000);

        // stray index writes while restoring identity
        set_rotation(0, 0, Q_ONE, 0, Q_ONE, 1'b1);
        send_point(32'sh1234_5678, -32'sh0765_4321, C_MIN);

        // oversized axis, sine and cosine of no real angle: clipping both ways
        set_rotation(Q_AXMAX, Q_AXMAX, Q_AXMAX, Q_ONE, Q_NONE, 1'b0);
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_MAX, 0, C_MIN);
        send_point(C_ONE, 0, 0);
        set_rotation(Q_AXMIN, Q_AXMIN, Q_AXMIN, Q_NONE, Q_ONE, 1'b0);
        send_point(C_MAX, C_MIN, C_MAX);
        send_point(1, -1, 1);

        // 45 degrees about a tilted axis, rounding of tiny coordinates
        set_rotation(0, Q_RT2, Q_RT2, Q_RT2, Q_RT2, 1'b0);
        send_point(1, 0, 0);
        send_point(0, 1, -1);
        send_point(3, 5, 7);

        // quarter turn about z
        set_rotation(0, 0, Q_ONE, Q_ONE, 0, 1'b0);
        send_point(C_ONE, 0, 0);
        send_point(0, C_ONE, 0);

        // random phases cycling through the flow-control modes
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 45; end
                default: begin send_idle_pct = 17; recv_stall_pct <= 17; end
            endcase
            pick_rotation(ph);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                // receiver backs off while points keep coming
                if (ph == HOLD_PHASE && n == PHASE_POINTS / 4)
                    hold_token <= hold_token + 1;
                // sender waits for the pipeline to empty mid-phase
                if (ph == DRAIN_PHASE && n == PHASE_POINTS / 2)
                    drain();
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
        end

        drain();
        $display("%0d points over %0d rotation settings, %0d results checked, %0d clipped",
                 points_sent, settings_used, checked, clipped);
        $display("flow control covered free running, sender gaps, result stalls and a hold-off");
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
